// ===== sv/bole_pkg.sv =====
package bole_pkg;

  localparam int CapacityDefault = 64;

  localparam int FuncW   = 2;
  localparam int KeyW    = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT    = 2'd0,
    FUNC_DEL_KEY   = 2'd1,
    FUNC_DEL_FIRST = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

// ===== sv/bounded_ordered_list_engine.sv =====
// channel | signals                                          | dir
// --------+--------------------------------------------------+----
// in      | in_valid_i, in_ready_o, func_i, key_value_i      | in
// out     | out_valid_o, out_ready_i, status_o, entry_count_o,| out
//         | head_key_o, tail_key_o                           |
//
// Insert: straight to DONE when full, else INS_POP, then INS_LINK unless the list was
// empty. Both deletes: straight to DONE when empty, else a WALK over the
// link memory, then HEAD_RD for the new head key when the head goes and others remain.
// A request is taken only in idle; a result waiting in the output register does not
// block the next request, but a finished one holds until the output is free.
// Reset clears the list at once (no clearing pass); slot memories need no reset.
module bounded_ordered_list_engine #(
  parameter int CAPACITY = bole_pkg::CapacityDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bole_pkg::FuncW-1:0]          func_i,
  input  logic signed [bole_pkg::KeyW-1:0]    key_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bole_pkg::StatusW-1:0]        status_o,
  output logic [bole_pkg::CountW-1:0]         entry_count_o,
  output logic signed [bole_pkg::KeyW-1:0]    head_key_o,
  output logic signed [bole_pkg::KeyW-1:0]    tail_key_o
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = bole_pkg::KeyW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_POP  = 3'd1;
  localparam logic [2:0] S_INS_LINK = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_HEAD_RD  = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [KW-1:0] key_mem  [CAPACITY];
  logic [SW-1:0] next_mem [CAPACITY];
  logic [SW-1:0] free_mem [CAPACITY];

  logic [2:0]                   state_q, state_d;
  logic [bole_pkg::FuncW-1:0]   func_q, func_d;
  logic [KW-1:0]                key_q, key_d;
  logic [bole_pkg::StatusW-1:0] status_q, status_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                free_cnt_q, free_cnt_d;
  logic [CW-1:0]                fresh_q, fresh_d;
  logic [CW-1:0]                iter_q, iter_d;
  logic [SW-1:0]                head_slot_q, head_slot_d;
  logic [SW-1:0]                tail_slot_q, tail_slot_d;
  logic [SW-1:0]                cur_q, cur_d;
  logic [SW-1:0]                prev_q, prev_d;
  logic [KW-1:0]                head_key_q, head_key_d;
  logic [KW-1:0]                tail_key_q, tail_key_d;
  logic [KW-1:0]                prev_key_q, prev_key_d;

  logic                         out_valid_q, out_valid_d;
  logic [bole_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [bole_pkg::CountW-1:0]  out_count_q, out_count_d;
  logic [KW-1:0]                out_head_q, out_head_d;
  logic [KW-1:0]                out_tail_q, out_tail_d;

  logic [KW-1:0] key_rd;
  logic [SW-1:0] next_rd;
  logic [SW-1:0] free_rd;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] free_rd_addr;

  logic          key_we;
  logic [SW-1:0] key_wa;
  logic          next_we;
  logic [SW-1:0] next_wa;
  logic [SW-1:0] next_wd;
  logic          free_we;

  logic [SW-1:0] new_slot;
  logic [CW-1:0] iter_inc;
  logic          hit;
  logic          in_acc;

  assign rd_addr      = (state_q == S_IDLE) ? head_slot_q : next_rd;
  assign free_rd_addr = SW'(free_cnt_q - CW'(1));
  assign new_slot     = (free_cnt_q != '0) ? free_rd : fresh_q[SW-1:0];
  assign iter_inc     = iter_q + CW'(1);
  assign hit          = (func_q == bole_pkg::FUNC_DEL_FIRST) || (key_rd == key_q);
  assign in_ready_o   = (state_q == S_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    key_rd  <= key_mem[rd_addr];
    next_rd <= next_mem[rd_addr];
    free_rd <= free_mem[free_rd_addr];
    if (key_we) begin
      key_mem[key_wa] <= key_q;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (free_we) begin
      free_mem[free_cnt_q[SW-1:0]] <= cur_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    key_d        = key_q;
    status_d     = status_q;
    count_d      = count_q;
    free_cnt_d   = free_cnt_q;
    fresh_d      = fresh_q;
    iter_d       = iter_q;
    head_slot_d  = head_slot_q;
    tail_slot_d  = tail_slot_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    head_key_d   = head_key_q;
    tail_key_d   = tail_key_q;
    prev_key_d   = prev_key_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_head_d   = out_head_q;
    out_tail_d   = out_tail_q;
    key_we       = 1'b0;
    key_wa       = new_slot;
    next_we      = 1'b0;
    next_wa      = new_slot;
    next_wd      = head_slot_q;
    free_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d     = func_i;
          key_d      = key_value_i;
          status_d   = bole_pkg::ST_OK;
          state_d    = S_DONE;
          cur_d      = head_slot_q;
          prev_d     = tail_slot_q;
          prev_key_d = tail_key_q;
          iter_d     = '0;
          case (func_i)
            bole_pkg::FUNC_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = bole_pkg::ST_FULL;
              end else begin
                state_d = S_INS_POP;
              end
            end
            bole_pkg::FUNC_DEL_KEY, bole_pkg::FUNC_DEL_FIRST: begin
              if (count_q == '0) begin
                status_d = bole_pkg::ST_EMPTY;
              end else begin
                state_d = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_POP: begin
        key_we = 1'b1;
        cur_d  = new_slot;
        if (free_cnt_q != '0) begin
          free_cnt_d = free_cnt_q - CW'(1);
        end else begin
          fresh_d = fresh_q + CW'(1);
        end
        next_we = 1'b1;
        if (count_q == '0) begin
          next_wd     = new_slot;
          head_slot_d = new_slot;
          tail_slot_d = new_slot;
          head_key_d  = key_q;
          tail_key_d  = key_q;
          count_d     = CW'(1);
          state_d     = S_DONE;
        end else begin
          state_d = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        next_we     = 1'b1;
        next_wa     = tail_slot_q;
        next_wd     = cur_q;
        tail_slot_d = cur_q;
        tail_key_d  = key_q;
        count_d     = count_q + CW'(1);
        state_d     = S_DONE;
      end
      S_WALK: begin
        if (hit) begin
          free_we    = 1'b1;
          free_cnt_d = free_cnt_q + CW'(1);
          count_d    = count_q - CW'(1);
          state_d    = S_DONE;
          if (count_q != CW'(1)) begin
            next_we = 1'b1;
            next_wa = prev_q;
            next_wd = next_rd;
            if (cur_q == tail_slot_q) begin
              tail_slot_d = prev_q;
              tail_key_d  = prev_key_q;
            end
            if (cur_q == head_slot_q) begin
              head_slot_d = next_rd;
              state_d     = S_HEAD_RD;
            end
          end
        end else if (iter_inc == count_q) begin
          status_d = bole_pkg::ST_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          prev_d     = cur_q;
          prev_key_d = key_rd;
          cur_d      = next_rd;
          iter_d     = iter_inc;
        end
      end
      S_HEAD_RD: begin
        head_key_d = key_rd;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_count_d  = bole_pkg::CountW'(count_q);
          out_head_d   = (count_q == '0) ? '0 : head_key_q;
          out_tail_d   = (count_q == '0) ? '0 : tail_key_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      free_cnt_q  <= '0;
      fresh_q     <= '0;
      tail_slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      free_cnt_q  <= free_cnt_d;
      fresh_q     <= fresh_d;
      tail_slot_q <= tail_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    status_q     <= status_d;
    iter_q       <= iter_d;
    head_slot_q  <= head_slot_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    head_key_q   <= head_key_d;
    tail_key_q   <= tail_key_d;
    prev_key_q   <= prev_key_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_head_q   <= out_head_d;
    out_tail_q   <= out_tail_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign head_key_o    = out_head_q;
  assign tail_key_o    = out_tail_q;

endmodule
